// ===== hdl/dqe_pkg.sv =====
// Shared types, constants and header byte table for the DNS query encoder.
// Has no dependencies. Every other file in hdl/ imports it.
package dqe_pkg;

  localparam int HDR_LEN   = 12;
  localparam int TAIL_LEN  = 5;
  localparam int LABEL_MAX = 63;
  localparam int NAME_MAX  = 255;

  localparam logic [7:0] DOT_CHAR = 8'd46;

  localparam logic [15:0] FLAGS_RESET = 16'h0100;
  localparam logic [15:0] QTYPE_RESET = 16'h0001;
  localparam logic [15:0] QCLASS_RESET = 16'h0001;

  // configuration register indexes
  localparam logic [1:0] REG_FLAGS  = 2'd0;
  localparam logic [1:0] REG_QTYPE  = 2'd1;
  localparam logic [1:0] REG_QCLASS = 2'd2;

  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_END  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  name_char;
    logic [15:0] query_id;
  } item_t;

  typedef struct packed {
    logic [8:0] out_offset;
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } result_t;

  typedef struct packed {
    logic [15:0] header_flags;
    logic [15:0] query_type;
    logic [15:0] query_class;
  } cfg_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_HEAD,
    PH_TAIL
  } phase_t;

  // byte idx of the 12-byte message header
  function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] id,
                                          input logic [15:0] flags);
    logic [7:0] b;
    b = 8'd0;
    case (idx)
      4'd0: b = id[15:8];
      4'd1: b = id[7:0];
      4'd2: b = flags[15:8];
      4'd3: b = flags[7:0];
      4'd5: b = 8'd1;   // question count low byte
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/dns_query_encoder.sv =====
// DNS query encoder top level: config registers, sequencer, result register.
// Depends on dqe_pkg, dqe_cfg, dqe_seq and dqe_out_reg.
//
// Usage:
//   Request channel (item_valid / item_stall / item): one name character per
//   request (mode 0), then one end request (mode 1). query_id is taken from
//   the first request of a name.
//   Result channel (result_valid / result_stall / result): (offset, byte)
//   writes into a message buffer; last marks the final write of a message,
//   error marks a rejected name (empty, label over 63, name over 255 bytes).
//   Config port (cfg_we / cfg_index / cfg_data): flags, qtype, qclass; write
//   only while idle.
// Timing:
//   A request is registered, and its results pass through the result register.
//   Characters stream at one per cycle while the result channel does not stall.
//   The first request of a name also emits the 12 header bytes, the end request
//   the length byte of an open label, root, type and class; the sequencer's
//   single result port emits them one by one, and item_stall is held meanwhile.
//   A stall on the result channel holds the result register and backs up
//   into item_stall in the same cycle.
// Reset clears all name state and loads the default config (flags 0x0100,
//   type 1, class 1); no result is pending after reset.
module dns_query_encoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  dqe_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output dqe_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import dqe_pkg::*;

  cfg_t    cfg;
  logic    push_valid;
  logic    push_ready;
  result_t push_data;

  dqe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // per-request sequencing: header burst, body byte, trailer burst
  dqe_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // result register decouples the sequencer from the receiver
  dqe_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .push_valid   (push_valid),
    .push_data    (push_data),
    .push_ready   (push_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== hdl/dqe_cfg.sv =====
// Configuration registers: flags, query type and query class.
// Depends on dqe_pkg.
module dqe_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output dqe_pkg::cfg_t       cfg
);
  import dqe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_flags <= FLAGS_RESET;
      cfg.query_type   <= QTYPE_RESET;
      cfg.query_class  <= QCLASS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FLAGS:  cfg.header_flags <= cfg_data;
        REG_QTYPE:  cfg.query_type   <= cfg_data;
        REG_QCLASS: cfg.query_class  <= cfg_data;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

endmodule

// ===== hdl/dqe_seq.sv =====
// Request register, name state and result sequencer of the DNS query encoder.
// Depends on dqe_pkg. Feeds dqe_out_reg one result per cycle while push_ready allows.
module dqe_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  dqe_pkg::item_t    item,
  input  dqe_pkg::cfg_t     cfg,
  output logic              push_valid,
  output dqe_pkg::result_t  push_data,
  input  logic              push_ready
);
  import dqe_pkg::*;

  // held request
  logic  held;
  item_t req;

  // sequencer
  phase_t     phase, phase_next;
  logic [3:0] cnt, cnt_next;

  // name state
  logic       in_name, in_name_next;
  logic [8:0] write_pos, write_pos_next;
  logic [8:0] label_start, label_start_next;
  logic [6:0] label_len, label_len_next;
  logic       any_label, any_label_next;
  logic       failed, failed_next;

  logic       emit, done, advance, load;
  result_t    res;

  logic [9:0] used;
  logic [9:0] need;
  logic       too_long;
  logic [8:0] char_pos;

  assign used     = {1'b0, write_pos} - 10'(HDR_LEN);
  assign need     = (label_len == 7'd0) ? 10'd2 : 10'd1;
  assign too_long = (8'(label_len) + 8'd1 > 8'(LABEL_MAX)) ||
                    (used + need + 10'd1 > 10'(NAME_MAX));
  assign char_pos = (label_len == 7'd0) ? write_pos + 9'd1 : write_pos;

  assign advance    = !emit || push_ready;
  assign load       = !held || (done && advance);
  assign item_stall = !load;
  assign push_valid = held && emit;
  assign push_data  = res;

  // next phase
  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    unique case (phase)
      PH_START: begin
        if (!in_name && req.mode == MODE_CHAR) begin
          phase_next = PH_HEAD;
          cnt_next   = 4'd1;
        end else if (in_name && req.mode == MODE_END && !failed && any_label) begin
          phase_next = PH_TAIL;
          cnt_next   = 4'd0;
        end
      end
      PH_HEAD: begin
        if (cnt == 4'(HDR_LEN - 1)) begin
          phase_next = PH_START;  // then handle the character itself
          cnt_next   = 4'd0;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      PH_TAIL: begin
        if (cnt == 4'(TAIL_LEN - 1)) begin
          phase_next = PH_START;
          cnt_next   = 4'd0;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      default: begin
        phase_next = PH_START;
        cnt_next   = 4'd0;
      end
    endcase
  end

  // result and name state
  always_comb begin
    emit             = 1'b0;
    done             = 1'b0;
    res              = '0;
    in_name_next     = in_name;
    write_pos_next   = write_pos;
    label_start_next = label_start;
    label_len_next   = label_len;
    any_label_next   = any_label;
    failed_next      = failed;
    unique case (phase)
      PH_START: begin
        if (!in_name && req.mode == MODE_END) begin
          emit      = 1'b1;
          res.last  = 1'b1;
          res.error = 1'b1;
          done      = 1'b1;
        end else if (!in_name) begin
          emit             = 1'b1;
          res.out_byte     = hdr_byte(4'd0, req.query_id, cfg.header_flags);
          in_name_next     = 1'b1;
          write_pos_next   = 9'(HDR_LEN);
          label_start_next = 9'(HDR_LEN);
          label_len_next   = 7'd0;
          any_label_next   = 1'b0;
          failed_next      = 1'b0;
        end else if (req.mode == MODE_CHAR) begin
          done = 1'b1;
          if (failed) begin
            // swallow characters after a limit was broken
          end else if (req.name_char == DOT_CHAR) begin
            if (label_len != 7'd0) begin
              emit           = 1'b1;
              res.out_offset = label_start;
              res.out_byte   = 8'(label_len);
              label_len_next = 7'd0;
            end
          end else if (too_long) begin
            failed_next = 1'b1;
          end else begin
            emit           = 1'b1;
            res.out_offset = char_pos;
            res.out_byte   = req.name_char;
            if (label_len == 7'd0) label_start_next = write_pos;
            write_pos_next = char_pos + 9'd1;
            label_len_next = label_len + 7'd1;
            any_label_next = 1'b1;
          end
        end else if (failed || !any_label) begin
          emit      = 1'b1;
          res.last  = 1'b1;
          res.error = 1'b1;
          done      = 1'b1;
        end else if (label_len != 7'd0) begin
          // close the open label, trailer follows
          emit           = 1'b1;
          res.out_offset = label_start;
          res.out_byte   = 8'(label_len);
        end
        if (done && req.mode == MODE_END) begin
          in_name_next     = 1'b0;
          write_pos_next   = 9'd0;
          label_start_next = 9'd0;
          label_len_next   = 7'd0;
          any_label_next   = 1'b0;
          failed_next      = 1'b0;
        end
      end
      PH_HEAD: begin
        emit           = 1'b1;
        res.out_offset = {5'd0, cnt};
        res.out_byte   = hdr_byte(cnt, req.query_id, cfg.header_flags);
      end
      PH_TAIL: begin
        emit           = 1'b1;
        res.out_offset = write_pos + 9'(cnt);
        case (cnt)
          4'd1: res.out_byte = cfg.query_type[15:8];
          4'd2: res.out_byte = cfg.query_type[7:0];
          4'd3: res.out_byte = cfg.query_class[15:8];
          4'd4: res.out_byte = cfg.query_class[7:0];
          default: res.out_byte = 8'd0;  // root label
        endcase
        if (cnt == 4'(TAIL_LEN - 1)) begin
          res.last         = 1'b1;
          done             = 1'b1;
          in_name_next     = 1'b0;
          write_pos_next   = 9'd0;
          label_start_next = 9'd0;
          label_len_next   = 7'd0;
          any_label_next   = 1'b0;
          failed_next      = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) req <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held        <= 1'b0;
      phase       <= PH_START;
      cnt         <= 4'd0;
      in_name     <= 1'b0;
      write_pos   <= 9'd0;
      label_start <= 9'd0;
      label_len   <= 7'd0;
      any_label   <= 1'b0;
      failed      <= 1'b0;
    end else begin
      if (load) held <= item_valid;
      if (held && advance) begin
        phase       <= phase_next;
        cnt         <= cnt_next;
        in_name     <= in_name_next;
        write_pos   <= write_pos_next;
        label_start <= label_start_next;
        label_len   <= label_len_next;
        any_label   <= any_label_next;
        failed      <= failed_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_burst_has_req: assert property (@(posedge clk) disable iff (rst)
    phase != PH_START |-> held)
    else $error("header or trailer burst without a held request");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    in_name |-> write_pos >= 9'(HDR_LEN) && write_pos <= 9'(HDR_LEN + NAME_MAX - 1))
    else $error("write position out of message range");

  a_label_range: assert property (@(posedge clk) disable iff (rst)
    label_len <= 7'(LABEL_MAX))
    else $error("label length above limit");

  a_failed_in_name: assert property (@(posedge clk) disable iff (rst)
    (failed || any_label) |-> in_name)
    else $error("name flags set outside a name");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (push_valid && push_data.last) |-> done)
    else $error("last result does not end the request");
`endif

endmodule

// ===== hdl/dqe_out_reg.sv =====
// Result register between the sequencer and the result channel.
// Depends on dqe_pkg.
module dqe_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  dqe_pkg::result_t  push_data,
  output logic              push_ready,
  output logic              result_valid,
  input  logic              result_stall,
  output dqe_pkg::result_t  result
);
  import dqe_pkg::*;

  // slot frees when empty or when its result is taken this cycle
  assign push_ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (push_ready) begin
      result_valid <= push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ready && push_valid) result <= push_data;
  end

endmodule
